// File: rtl/tvsa_pkg.sv
// ---------------------------------------------------------------------------
// tvsa_pkg
// Shared types and constants of the timed voice slot allocator.
// ---------------------------------------------------------------------------
package tvsa_pkg;

   localparam int DEF_NUM_SLOTS    = 8;
   localparam int DEF_NUM_TRIGGERS = 32;
   localparam int DEF_TIME_BITS    = 24;

   localparam int TRIG_FIELD_W  = 8;
   localparam int CUE_W         = 32;
   localparam int TIME_FIELD_W  = 24;
   localparam int VOLUME_W      = 16;
   localparam int STATUS_W      = 2;
   localparam int SLOT_FIELD_W  = 3;
   localparam int COUNT_FIELD_W = 4;

   localparam logic [VOLUME_W-1:0] VOLUME_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      REQ_PLAY     = 2'd0,
      REQ_TICK     = 2'd1,
      REQ_STOP_ALL = 2'd2,
      REQ_SET_MAP  = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_TRIGGER = 2'd1,
      STATUS_NO_CUE      = 2'd2,
      STATUS_NO_SLOT     = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // one command to every slot cell in the row
   typedef struct packed {
      logic start;
      logic tick;
      logic clear;
   } cell_ctrl_type;

   // saturate a time field to the internal time range
   function automatic logic [31:0] clamp_time(logic [TIME_FIELD_W-1:0] t,
                                              logic [31:0] max_v);
      logic [31:0] wide;
      wide = 32'(t);
      return (wide > max_v) ? max_v : wide;
   endfunction

endpackage

// File: rtl/tvsa_slot_cell.sv
// ---------------------------------------------------------------------------
// tvsa_slot_cell
// One timed playback slot: claims itself on a play when all lower slots
// are busy, ages on a tick and frees itself when its duration is reached.
// ---------------------------------------------------------------------------
module tvsa_slot_cell #(
   parameter int TIME_BITS = tvsa_pkg::DEF_TIME_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tvsa_pkg::cell_ctrl_type         ctrl,
   input  logic                            claim_in,
   input  logic [TIME_BITS-1:0]            step,
   input  logic [tvsa_pkg::TRIG_FIELD_W-1:0] trigger,
   input  logic [tvsa_pkg::CUE_W-1:0]      cue,
   input  logic [TIME_BITS-1:0]            duration,
   input  logic [tvsa_pkg::VOLUME_W-1:0]   volume,
   output logic                            claim_out,
   output logic                            granted,
   output logic                            active_next
);
   import tvsa_pkg::*;

   logic                    active_ff, active_in;
   logic [TIME_BITS-1:0]    elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0]    duration_ff;
   logic [TRIG_FIELD_W-1:0] trigger_ff;
   logic [CUE_W-1:0]        cue_ff;
   logic [VOLUME_W-1:0]     volume_ff;
   logic [TIME_BITS:0]      sum;
   logic [TIME_BITS-1:0]    sum_sat;
   logic                    aging;

   // a lower free slot already took the claim
   assign claim_out = claim_in | ~active_ff;
   assign granted   = ctrl.start & ~active_ff & ~claim_in;
   assign aging     = ctrl.tick & active_ff;

   always_comb begin
      sum     = {1'b0, elapsed_ff} + {1'b0, step};
      sum_sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
   end

   always_comb begin
      active_in  = active_ff;
      elapsed_in = elapsed_ff;
      if (ctrl.clear) begin
         active_in = 1'b0;
      end else if (granted) begin
         active_in  = 1'b1;
         elapsed_in = '0;
      end else if (aging) begin
         elapsed_in = sum_sat;
         active_in  = (sum_sat < duration_ff);
      end
   end

   assign active_next = active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      if (granted) begin
         duration_ff <= duration;
         trigger_ff  <= trigger;
         cue_ff      <= cue;
         volume_ff   <= volume;
      end
   end

   a_cue_set: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> cue_ff != '0)
      else $error("active slot holds cue zero");

   a_trigger_set: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> trigger_ff != '0)
      else $error("active slot holds trigger zero");

   a_identity_holds: assert property (@(posedge clock) disable iff (reset)
      active_ff && $past(active_ff) && !$past(reset)
         |-> $stable(cue_ff) && $stable(volume_ff) && $stable(duration_ff))
      else $error("playing slot was overwritten");

endmodule

// File: rtl/tvsa_cue_map.sv
// ---------------------------------------------------------------------------
// tvsa_cue_map
// Trigger-to-cue table: one write port, one registered read port, and a
// valid bit per entry so that an unwritten entry reads as zero after reset.
// ---------------------------------------------------------------------------
module tvsa_cue_map #(
   parameter int NUM_TRIGGERS = tvsa_pkg::DEF_NUM_TRIGGERS,
   parameter int TIME_BITS    = tvsa_pkg::DEF_TIME_BITS,
   localparam int TRIG_W      = $clog2(NUM_TRIGGERS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [TRIG_W-1:0]          rd_idx,
   input  logic                       wr_en,
   input  logic [TRIG_W-1:0]          wr_idx,
   input  logic [tvsa_pkg::CUE_W-1:0] wr_cue,
   input  logic [TIME_BITS-1:0]       wr_duration,
   output logic [tvsa_pkg::CUE_W-1:0] rd_cue,
   output logic [TIME_BITS-1:0]       rd_duration
);
   import tvsa_pkg::*;

   logic [CUE_W-1:0]     cue_mem [NUM_TRIGGERS];
   logic [TIME_BITS-1:0] duration_mem [NUM_TRIGGERS];
   logic [NUM_TRIGGERS-1:0] valid_ff;
   logic                 rd_valid_ff;
   logic [CUE_W-1:0]     rd_cue_ff;
   logic [TIME_BITS-1:0] rd_duration_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cue_mem[wr_idx]      <= wr_cue;
         duration_mem[wr_idx] <= wr_duration;
      end
      if (rd_en) begin
         rd_cue_ff      <= cue_mem[rd_idx];
         rd_duration_ff <= duration_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_cue      = rd_valid_ff ? rd_cue_ff : '0;
   assign rd_duration = rd_valid_ff ? rd_duration_ff : '0;

endmodule

// File: rtl/timed_voice_slot_allocator_core.sv
// ---------------------------------------------------------------------------
// timed_voice_slot_allocator_core
// Trigger-mapped cue player with a row of timed playback slots.
// ---------------------------------------------------------------------------
// Usage:
//   A request (req_valid/req_ready) carries a type: play a trigger, tick
//   time forward, stop all slots, or set one trigger's cue and duration.
//   Each request yields exactly one response (rsp_valid/rsp_ready) with a
//   status, the slot taken by a play, the active slot count after the
//   request and an any-playing flag.
//   csr_wr_en/csr_wr_data set the volume recorded into newly started slots;
//   write it only while no request is in flight.
// Timing:
//   A request is taken in the idle cycle while its trigger's table entry is
//   read; the execute state then updates the slot row and loads the
//   response register, stalling while that register is full and rsp_ready
//   is low. rsp_valid rises with that load. A new request is taken only
//   after the current one has updated the slot row.
// Reset clears all slots and marks every table entry unmapped; the block is
//   ready in the first cycle after reset. While the response register is
//   full and rsp_ready is low, a second request may be accepted but holds
//   in its update cycle until the response is taken.
// ---------------------------------------------------------------------------
module timed_voice_slot_allocator_core #(
   parameter int NUM_SLOTS    = tvsa_pkg::DEF_NUM_SLOTS,
   parameter int NUM_TRIGGERS = tvsa_pkg::DEF_NUM_TRIGGERS,
   parameter int TIME_BITS    = tvsa_pkg::DEF_TIME_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [tvsa_pkg::VOLUME_W-1:0]      csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [tvsa_pkg::TRIG_FIELD_W-1:0]  req_trigger_code,
   input  logic [tvsa_pkg::CUE_W-1:0]         req_new_cue,
   input  logic [tvsa_pkg::TIME_FIELD_W-1:0]  req_new_duration,
   input  logic [tvsa_pkg::TIME_FIELD_W-1:0]  req_time_step,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tvsa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tvsa_pkg::SLOT_FIELD_W-1:0]  rsp_slot_index,
   output logic [tvsa_pkg::COUNT_FIELD_W-1:0] rsp_active_slots,
   output logic                               rsp_any_playing
);
   import tvsa_pkg::*;

   localparam int TRIG_W = $clog2(NUM_TRIGGERS);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam logic [32:0] TIME_LIMIT = (33'd1 << TIME_BITS) - 33'd1;
   localparam logic [31:0] TIME_MAX   = TIME_LIMIT[31:0];
   localparam logic [TRIG_FIELD_W:0] TRIG_LIMIT = (TRIG_FIELD_W+1)'(NUM_TRIGGERS);

   state_type state_ff, state_in;
   logic      accept, advance;

   logic [VOLUME_W-1:0]     volume_ff;
   req_kind_type            kind_ff;
   logic [TRIG_FIELD_W-1:0] trig_ff;
   logic [CUE_W-1:0]        cue_ff;
   logic [TIME_BITS-1:0]    dur_ff;
   logic [TIME_BITS-1:0]    step_ff;
   logic                    trig_ok_ff;

   logic                    req_trig_ok;
   logic [TRIG_W-1:0]       rd_idx;
   logic [CUE_W-1:0]        map_cue;
   logic [TIME_BITS-1:0]    map_duration;
   logic                    map_wr;

   cell_ctrl_type           ctrl;
   status_type              status;
   logic [NUM_SLOTS:0]      claim;
   logic [NUM_SLOTS-1:0]    grant_vec;
   logic [NUM_SLOTS-1:0]    active_vec;
   logic [SLOT_W-1:0]       grant_idx;
   logic [CNT_W-1:0]        count;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [CNT_W-1:0]        rsp_count_ff;

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      advance   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: advance   = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            advance   = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         volume_ff <= VOLUME_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            volume_ff <= csr_wr_data;
         end
      end
   end

   // ---------------- request capture and table read ----------------
   assign req_trig_ok = {1'b0, req_trigger_code} < TRIG_LIMIT;
   assign rd_idx      = req_trig_ok ? req_trigger_code[TRIG_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_kind_type'(req_type);
         trig_ff    <= req_trigger_code;
         trig_ok_ff <= req_trig_ok;
         cue_ff     <= req_new_cue;
         dur_ff     <= TIME_BITS'(clamp_time(req_new_duration, TIME_MAX));
         step_ff    <= TIME_BITS'(clamp_time(req_time_step, TIME_MAX));
      end
   end

   assign map_wr = advance && (kind_ff == REQ_SET_MAP) && trig_ok_ff;

   tvsa_cue_map #(
      .NUM_TRIGGERS (NUM_TRIGGERS),
      .TIME_BITS    (TIME_BITS)
   ) u_map (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_idx      (rd_idx),
      .wr_en       (map_wr),
      .wr_idx      (trig_ff[TRIG_W-1:0]),
      .wr_cue      (cue_ff),
      .wr_duration (dur_ff),
      .rd_cue      (map_cue),
      .rd_duration (map_duration)
   );

   // ---------------- status and slot row commands ----------------
   always_comb begin
      status = STATUS_OK;
      case (kind_ff)
         REQ_PLAY: begin
            if (trig_ff == '0 || !trig_ok_ff) begin
               status = STATUS_BAD_TRIGGER;
            end else if (map_cue == '0) begin
               status = STATUS_NO_CUE;
            end else if (!claim[NUM_SLOTS]) begin
               status = STATUS_NO_SLOT;
            end
         end
         REQ_SET_MAP: begin
            if (!trig_ok_ff) begin
               status = STATUS_BAD_TRIGGER;
            end
         end
         default: status = STATUS_OK;
      endcase
   end

   always_comb begin
      ctrl.start = advance && (kind_ff == REQ_PLAY) && (status == STATUS_OK);
      ctrl.tick  = advance && (kind_ff == REQ_TICK) && (step_ff != '0);
      ctrl.clear = advance && (kind_ff == REQ_STOP_ALL);
   end

   assign claim[0] = 1'b0;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      tvsa_slot_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .claim_in    (claim[i]),
         .step        (step_ff),
         .trigger     (trig_ff),
         .cue         (map_cue),
         .duration    (map_duration),
         .volume      (volume_ff),
         .claim_out   (claim[i+1]),
         .granted     (grant_vec[i]),
         .active_next (active_vec[i])
      );
   end

   always_comb begin
      grant_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (grant_vec[i]) begin
            grant_idx = grant_idx | SLOT_W'(i);
         end
      end
   end

   assign count = CNT_W'($countones(active_vec));

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status;
         rsp_slot_ff   <= grant_idx;
         rsp_count_ff  <= count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = SLOT_FIELD_W'(rsp_slot_ff);
   assign rsp_active_slots = COUNT_FIELD_W'(rsp_count_ff);
   assign rsp_any_playing  = (rsp_count_ff != '0);

   a_one_grant: assert property (@(posedge clock) disable iff (reset)
      $onehot0(grant_vec))
      else $error("more than one slot claimed a play");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |-> rsp_slot_ff == '0)
      else $error("rejected request reports a slot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff <= CNT_W'(NUM_SLOTS))
      else $error("active count exceeds slot count");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && !advance |=> state_ff == ST_EXEC && $stable(kind_ff))
      else $error("stalled request lost");

endmodule
